// File: design/tis_pkg.sv
// shared types and constants for the trie insert/search core
package tis_pkg;

   // fixed width of the letter field
   localparam int unsigned LETTER_W = 5;

   // action codes
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_SEARCH = 1'b1;

   // memory access strobes from the walk controller to the node store
   typedef struct packed {
      logic child_rd;
      logic child_wr;
      logic flag_rd;
      logic flag_wr;
   } tis_mem_ctl_type;

endpackage

// File: design/trie_insert_search_core.sv
// trie insert/search core: walks a node pool one letter request at a time
//
//   channel | direction | ports                                         | handshake
//   req     | in        | req_action req_letter req_last req_empty_word | req_valid/req_ready
//   rsp     | out       | rsp_found rsp_overflow                        | rsp_valid/rsp_ready
//
// a letter that does not end the word: child table read, then the optional child
// write and node update; only the accept once the walk of the word has stopped
// a final letter walks, then reads the word end flag and writes it back; it skips the
// walk when the walk has stopped, as an empty word does; the result is set at write back
// after reset a clearing pass sweeps all NODE_COUNT*ALPHABET_SIZE child table slots
// (6656 by default) and the flags with req_ready low
// a result held in rsp does not stop a new request; only the next result waits
module trie_insert_search_core #(
   parameter int NODE_COUNT    = 256,
   parameter int ALPHABET_SIZE = 26
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic [tis_pkg::LETTER_W-1:0]  req_letter,
   input  logic                          req_last,
   input  logic                          req_empty_word,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic                          rsp_overflow
);

   localparam int DEPTH = NODE_COUNT * ALPHABET_SIZE;
   localparam int AW    = $clog2(DEPTH);
   localparam int NW    = $clog2(NODE_COUNT);

   // walk states
   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_WALK    = 2'd1;
   localparam logic [1:0] ST_FLAG_RD = 2'd2;
   localparam logic [1:0] ST_FLAG_WB = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic          act_ff, act_in;       // action of the request in flight
   logic          fin_ff, fin_in;       // request ends the word
   logic [NW-1:0] cur_ff, cur_in;       // current node of the walk
   logic [NW:0]   free_ff, free_in;     // next free node, may reach NODE_COUNT
   logic          miss_ff, miss_in;
   logic          ovf_ff, ovf_in;
   logic [AW-1:0] slot_ff, slot_in;     // child table slot being walked
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_found_ff, rsp_found_in;
   logic          rsp_overflow_ff, rsp_overflow_in;

   tis_pkg::tis_mem_ctl_type mem_ctl;
   logic [AW-1:0] child_addr;
   logic [NW-1:0] child_rdata;
   logic          flag_rdata;
   logic          clear_busy;
   logic [AW-1:0] req_slot;
   logic          accept;
   logic          ins;

   tis_store #(
      .NODE_COUNT    (NODE_COUNT),
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .ctl         (mem_ctl),
      .child_addr  (child_addr),
      .child_wdata (free_ff[NW-1:0]),
      .child_rdata (child_rdata),
      .flag_addr   (cur_ff),
      .flag_rdata  (flag_rdata),
      .clear_busy  (clear_busy)
   );

   assign req_ready = (state_ff == ST_IDLE) && !clear_busy;
   assign accept    = req_valid && req_ready;
   assign ins       = (act_ff == tis_pkg::ACT_INSERT);

   // slot of the requested letter under the current node
   assign req_slot = AW'(AW'(cur_ff) * AW'(ALPHABET_SIZE) + AW'(req_letter));

   // the write in the walk state uses the held slot, the read uses the new one
   assign child_addr = (state_ff == ST_WALK) ? slot_ff : req_slot;

   always_comb begin
      state_in        = state_ff;
      act_in          = act_ff;
      fin_in          = fin_ff;
      cur_in          = cur_ff;
      free_in         = free_ff;
      miss_in         = miss_ff;
      ovf_in          = ovf_ff;
      slot_in         = slot_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_found_in    = rsp_found_ff;
      rsp_overflow_in = rsp_overflow_ff;
      mem_ctl         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_in  = req_action;
               fin_in  = req_last || req_empty_word;
               slot_in = req_slot;
               if (req_empty_word) begin
                  // word ends at the current node, no letter step
                  state_in = ST_FLAG_RD;
               end else if (miss_ff || ovf_ff) begin
                  // walk already stopped for this word
                  state_in = req_last ? ST_FLAG_RD : ST_IDLE;
               end else if (32'(req_letter) >= ALPHABET_SIZE) begin
                  // letter outside the alphabet
                  miss_in  = 1'b1;
                  state_in = req_last ? ST_FLAG_RD : ST_IDLE;
               end else begin
                  mem_ctl.child_rd = 1'b1;
                  state_in         = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (child_rdata == '0) begin
               if (!ins) begin
                  miss_in = 1'b1;
               end else if (free_ff >= (NW+1)'(NODE_COUNT)) begin
                  // pool exhausted
                  ovf_in = 1'b1;
               end else begin
                  // allocate the next free node as the child
                  mem_ctl.child_wr = 1'b1;
                  cur_in           = free_ff[NW-1:0];
                  free_in          = free_ff + (NW+1)'(1);
               end
            end else begin
               cur_in = child_rdata;
            end
            state_in = fin_ff ? ST_FLAG_RD : ST_IDLE;
         end
         ST_FLAG_RD: begin
            mem_ctl.flag_rd = 1'b1;
            state_in        = ST_FLAG_WB;
         end
         ST_FLAG_WB: begin
            // wait here only while an older result is still not taken
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = 1'b0;
               rsp_overflow_in = 1'b0;
               if (ins) begin
                  if (ovf_ff) begin
                     rsp_overflow_in = 1'b1;
                  end else if (!miss_ff) begin
                     rsp_found_in    = flag_rdata;
                     mem_ctl.flag_wr = 1'b1;
                  end
               end else begin
                  rsp_found_in = flag_rdata && !miss_ff && !ovf_ff;
               end
               // back to the root for the next word
               cur_in   = '0;
               miss_in  = 1'b0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         free_ff      <= (NW+1)'(1);
         miss_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         free_ff      <= free_in;
         miss_ff      <= miss_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff          <= act_in;
      fin_ff          <= fin_in;
      slot_ff         <= slot_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_overflow = rsp_overflow_ff;

   // free pointer stays within the pool bounds
   a_free_range: assert property (@(posedge clock) disable iff (reset)
      (free_ff >= (NW+1)'(1)) && (free_ff <= (NW+1)'(NODE_COUNT)))
      else $error("free node pointer out of range");

   // a miss and an overflow never stand together for one word
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      !(miss_ff && ovf_ff))
      else $error("miss and overflow both recorded");

   // the walk step only follows a request accepted in idle
   a_walk_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> ($past(state_ff) == ST_IDLE && $past(accept)))
      else $error("walk entered without an accepted request");

   // an overflowed insert never reports found
   a_rsp_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_overflow))
      else $error("result with found and overflow");

endmodule

// File: design/tis_store.sv
// node store: child table and word end flags, with the clearing pass after reset
module tis_store #(
   parameter int NODE_COUNT    = 256,
   parameter int ALPHABET_SIZE = 26
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  tis_pkg::tis_mem_ctl_type                    ctl,
   input  logic [$clog2(NODE_COUNT*ALPHABET_SIZE)-1:0] child_addr,
   input  logic [$clog2(NODE_COUNT)-1:0]               child_wdata,
   output logic [$clog2(NODE_COUNT)-1:0]               child_rdata,
   input  logic [$clog2(NODE_COUNT)-1:0]               flag_addr,
   output logic                                        flag_rdata,
   output logic                                        clear_busy
);

   localparam int DEPTH = NODE_COUNT * ALPHABET_SIZE;
   localparam int AW    = $clog2(DEPTH);
   localparam int NW    = $clog2(NODE_COUNT);

   logic [NW-1:0] child_mem [DEPTH];
   logic          flag_mem  [NODE_COUNT];

   logic          clr_busy_ff;
   logic          clr_busy_in;
   logic [AW-1:0] clr_addr_ff;
   logic [AW-1:0] clr_addr_in;
   logic [NW-1:0] child_rdata_ff;
   logic          flag_rdata_ff;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // child table port
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         child_mem[clr_addr_ff] <= '0;
      end else if (ctl.child_wr) begin
         child_mem[child_addr] <= child_wdata;
      end
      if (ctl.child_rd) begin
         child_rdata_ff <= child_mem[child_addr];
      end
   end

   // word end flag port, cleared by the low part of the same sweep
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         if (32'(clr_addr_ff) < NODE_COUNT) begin
            flag_mem[clr_addr_ff[NW-1:0]] <= 1'b0;
         end
      end else if (ctl.flag_wr) begin
         flag_mem[flag_addr] <= 1'b1;
      end
      if (ctl.flag_rd) begin
         flag_rdata_ff <= flag_mem[flag_addr];
      end
   end

   assign child_rdata = child_rdata_ff;
   assign flag_rdata  = flag_rdata_ff;
   assign clear_busy  = clr_busy_ff;

endmodule
